/* rtl/core/tecac_pkg.sv */
// ----------------------------------------------------------------------------
// tecac_pkg
// Shared types and constants for the bridge-tree augment counter: default
// sizes, controller commands and the status word returned by the datapath.
// ----------------------------------------------------------------------------
package tecac_pkg;

    // default storage sizes
    localparam int DEF_MAX_NODES      = 4096;
    localparam int DEF_MAX_HALF_EDGES = 16384;

    // fixed field widths of the stream payload
    localparam int NODE_W  = 12;
    localparam int COUNT_W = 12;

    // controller commands, at most one per controller state
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLEAR_INIT,
        CMD_CLEAR_STEP,
        CMD_TAKE,
        CMD_CHECK,
        CMD_LA_RD,
        CMD_LA_WR,
        CMD_LB_RD,
        CMD_LB_WR,
        CMD_W_INIT,
        CMD_W_ROOT,
        CMD_W_EDGE,
        CMD_W_DISC,
        CMD_W_DECIDE,
        CMD_W_PUSH,
        CMD_P_ROOT,
        CMD_P_CRD,
        CMD_P_CWR,
        CMD_P_POP,
        CMD_P_LOAD,
        CMD_C_INIT,
        CMD_C_LIST,
        CMD_C_CA,
        CMD_C_DA,
        CMD_C_WA,
        CMD_C_DB,
        CMD_C_WB,
        CMD_L_INIT,
        CMD_L_RD,
        CMD_L_CHK,
        CMD_RESULT
    } cmd_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic edge_ok;
        logic fits;
        logic last;
        logic cursor_valid;
        logic visit_new;
        logic comp_root;
        logic comp_more;
        logic stack_last;
        logic count_done;
        logic leaf_done;
        logic clear_done;
        logic out_busy;
    } status_t;

endpackage

/* rtl/core/two_edge_connected_augment_count.sv */
// ----------------------------------------------------------------------------
// two_edge_connected_augment_count
// Counts the edges needed to make an undirected graph connected with no bridges.
// ----------------------------------------------------------------------------
// Edges arrive on the slave stream, one per request: tdata carries node_a
// and node_b, tlast marks the final edge. Each stored edge makes two
// read-modify-write passes on the single-port adjacency head memory.
// The final edge starts a depth-first bridge walk from node 1 that examines
// each half-edge, pushes each newly reached node and pops each finished one,
// closing a component at each component root; a degree pass over the bridges
// and a leaf pass over the components follow.
// The result request (edges_to_add, component_count, leaf_components,
// edge_overflow) is then held in an output register until the master side
// takes it; a stalled receiver only holds the block before the next result.
// After reset and after each result, a clearing sweep over all MAX_NODES
// entries resets the head, discovery and degree memories; tready stays low
// during the sweep and the walk. node_count, written through cfg_wr_en, survives
// results; the user must write it only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module two_edge_connected_augment_count
#(
    parameter int MAX_NODES      = tecac_pkg::DEF_MAX_NODES,
    parameter int MAX_HALF_EDGES = tecac_pkg::DEF_MAX_HALF_EDGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,     // node_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // node_a [11:0], node_b [23:12]
    input  logic        s_axis_tlast,    // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // edges_to_add, component_count,
                                         // leaf_components, edge_overflow, zero pad
);

    tecac_pkg::cmd_t    cmd;
    tecac_pkg::status_t status;
    logic [11:0] edges_to_add, component_count, leaf_components;
    logic        edge_overflow;

    // sequencer
    tecac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    // stores and counters
    tecac_datapath
    #(
        .MAX_NODES      (MAX_NODES),
        .MAX_HALF_EDGES (MAX_HALF_EDGES)
    )
    u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_node_a           (s_axis_tdata[11:0]),
        .in_node_b           (s_axis_tdata[23:12]),
        .in_last             (s_axis_tlast),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_edges_to_add    (edges_to_add),
        .out_component_count (component_count),
        .out_leaf_components (leaf_components),
        .out_edge_overflow   (edge_overflow)
    );

    assign m_axis_tdata = {3'b000, edge_overflow, leaf_components,
                           component_count, edges_to_add};

    // a finished walk always closes the root component
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[23:12] != 12'd0))
        else $error("result with no component");

    // leaf components never outnumber components
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[35:24] <= m_axis_tdata[23:12]))
        else $error("more leaves than components");

    // no edge is taken while a result command is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == tecac_pkg::CMD_RESULT) |-> !s_axis_tready)
        else $error("input open during result hand-off");

endmodule

/* rtl/core/tecac_ctrl.sv */
// ----------------------------------------------------------------------------
// tecac_ctrl
// Sequencer for loading, the depth-first bridge walk, the degree and leaf
// passes, the result hand-off and the store clearing sweep.
// ----------------------------------------------------------------------------
module tecac_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tecac_pkg::status_t status,
    output tecac_pkg::cmd_t    cmd,
    output logic               in_ready
);

    typedef enum logic [5:0] {
        S_CLR_INIT, S_CLR, S_IDLE, S_CHECK,
        S_LA_RD, S_LA_WR, S_LB_RD, S_LB_WR,
        S_W_INIT, S_W_ROOT, S_W_TOP, S_W_EDGE, S_W_DISC, S_W_DECIDE, S_W_PUSH,
        S_P_ROOT, S_P_CRD, S_P_CWR, S_P_POP, S_P_LOAD,
        S_C_INIT, S_C_TEST, S_C_LIST, S_C_CA, S_C_DA, S_C_WA, S_C_DB, S_C_WB,
        S_L_INIT, S_L_TEST, S_L_RD, S_L_CHK, S_WAIT_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = tecac_pkg::CMD_NOP;
        unique case (state_reg)
            S_CLR_INIT:
            begin
                cmd        = tecac_pkg::CMD_CLEAR_INIT;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd = tecac_pkg::CMD_CLEAR_STEP;
                if (status.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = tecac_pkg::CMD_TAKE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd = tecac_pkg::CMD_CHECK;
                if (status.edge_ok && status.fits)
                    state_next = S_LA_RD;
                else if (status.last)
                    state_next = S_W_INIT;
                else
                    state_next = S_IDLE;
            end
            S_LA_RD:
            begin
                cmd        = tecac_pkg::CMD_LA_RD;
                state_next = S_LA_WR;
            end
            S_LA_WR:
            begin
                cmd        = tecac_pkg::CMD_LA_WR;
                state_next = S_LB_RD;
            end
            S_LB_RD:
            begin
                cmd        = tecac_pkg::CMD_LB_RD;
                state_next = S_LB_WR;
            end
            S_LB_WR:
            begin
                cmd        = tecac_pkg::CMD_LB_WR;
                state_next = status.last ? S_W_INIT : S_IDLE;
            end
            S_W_INIT:
            begin
                cmd        = tecac_pkg::CMD_W_INIT;
                state_next = S_W_ROOT;
            end
            S_W_ROOT:
            begin
                cmd        = tecac_pkg::CMD_W_ROOT;
                state_next = S_W_TOP;
            end
            S_W_TOP:
            begin
                if (status.cursor_valid)
                    state_next = S_W_EDGE;
                else if (status.comp_root)
                    state_next = S_P_ROOT;
                else
                    state_next = S_P_POP;
            end
            S_W_EDGE:
            begin
                cmd        = tecac_pkg::CMD_W_EDGE;
                state_next = S_W_DISC;
            end
            S_W_DISC:
            begin
                cmd        = tecac_pkg::CMD_W_DISC;
                state_next = S_W_DECIDE;
            end
            S_W_DECIDE:
            begin
                cmd        = tecac_pkg::CMD_W_DECIDE;
                state_next = status.visit_new ? S_W_PUSH : S_W_TOP;
            end
            S_W_PUSH:
            begin
                cmd        = tecac_pkg::CMD_W_PUSH;
                state_next = S_W_TOP;
            end
            S_P_ROOT:
            begin
                cmd        = tecac_pkg::CMD_P_ROOT;
                state_next = S_P_CRD;
            end
            S_P_CRD:
            begin
                cmd        = tecac_pkg::CMD_P_CRD;
                state_next = S_P_CWR;
            end
            S_P_CWR:
            begin
                cmd        = tecac_pkg::CMD_P_CWR;
                state_next = status.comp_more ? S_P_CRD : S_P_POP;
            end
            S_P_POP:
            begin
                cmd        = tecac_pkg::CMD_P_POP;
                state_next = status.stack_last ? S_C_INIT : S_P_LOAD;
            end
            S_P_LOAD:
            begin
                cmd        = tecac_pkg::CMD_P_LOAD;
                state_next = S_W_TOP;
            end
            S_C_INIT:
            begin
                cmd        = tecac_pkg::CMD_C_INIT;
                state_next = S_C_TEST;
            end
            S_C_TEST:
            begin
                state_next = status.count_done ? S_L_INIT : S_C_LIST;
            end
            S_C_LIST:
            begin
                cmd        = tecac_pkg::CMD_C_LIST;
                state_next = S_C_CA;
            end
            S_C_CA:
            begin
                cmd        = tecac_pkg::CMD_C_CA;
                state_next = S_C_DA;
            end
            S_C_DA:
            begin
                cmd        = tecac_pkg::CMD_C_DA;
                state_next = S_C_WA;
            end
            S_C_WA:
            begin
                cmd        = tecac_pkg::CMD_C_WA;
                state_next = S_C_DB;
            end
            S_C_DB:
            begin
                cmd        = tecac_pkg::CMD_C_DB;
                state_next = S_C_WB;
            end
            S_C_WB:
            begin
                cmd        = tecac_pkg::CMD_C_WB;
                state_next = S_C_TEST;
            end
            S_L_INIT:
            begin
                cmd        = tecac_pkg::CMD_L_INIT;
                state_next = S_L_TEST;
            end
            S_L_TEST:
            begin
                state_next = status.leaf_done ? S_WAIT_OUT : S_L_RD;
            end
            S_L_RD:
            begin
                cmd        = tecac_pkg::CMD_L_RD;
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                cmd        = tecac_pkg::CMD_L_CHK;
                state_next = S_L_TEST;
            end
            S_WAIT_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = tecac_pkg::CMD_RESULT;
                    state_next = S_CLR_INIT;
                end
            end
            default:
            begin
                state_next = S_CLR_INIT;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR_INIT;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/core/tecac_datapath.sv */
// ----------------------------------------------------------------------------
// tecac_datapath
// Adjacency, walk and component stores with their counters; carries out one
// controller command per cycle and holds the result register.
// ----------------------------------------------------------------------------
module tecac_datapath
#(
    parameter int MAX_NODES      = tecac_pkg::DEF_MAX_NODES,
    parameter int MAX_HALF_EDGES = tecac_pkg::DEF_MAX_HALF_EDGES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tecac_pkg::cmd_t               cmd,
    output tecac_pkg::status_t            status,
    input  logic                          cfg_wr_en,
    input  logic [tecac_pkg::NODE_W-1:0]  cfg_wr_data,
    input  logic [tecac_pkg::NODE_W-1:0]  in_node_a,
    input  logic [tecac_pkg::NODE_W-1:0]  in_node_b,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tecac_pkg::COUNT_W-1:0] out_edges_to_add,
    output logic [tecac_pkg::COUNT_W-1:0] out_component_count,
    output logic [tecac_pkg::COUNT_W-1:0] out_leaf_components,
    output logic                          out_edge_overflow
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int HW = $clog2(MAX_HALF_EDGES);
    localparam int EW = HW + 1;
    localparam int CW = NW + 1;
    localparam logic [EW-1:0] EMPTY = EW'(MAX_HALF_EDGES);

    typedef struct packed {
        logic [NW-1:0] node;
        logic [EW-1:0] entry;
        logic [EW-1:0] cursor;
        logic [NW-1:0] disc;
        logic [NW-1:0] low;
    } frame_t;

    typedef struct packed {
        logic [NW-1:0] parent;
        logic [NW-1:0] child;
    } bridge_t;

    // control registers
    logic [tecac_pkg::NODE_W-1:0] node_count_reg;
    logic [EW-1:0] he_cnt_reg;
    logic [NW-1:0] vclk_reg;
    logic [NW-1:0] comps_reg;
    logic [NW-1:0] leaves_reg;
    logic [CW-1:0] bc_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] cp_reg;
    logic          ovf_reg;
    logic          out_valid_reg;

    // payload registers
    logic [tecac_pkg::NODE_W-1:0] a_reg;
    logic [tecac_pkg::NODE_W-1:0] b_reg;
    logic          last_reg;
    frame_t        f_reg;
    logic [NW-1:0] pend_node_reg;
    logic [EW-1:0] pend_entry_reg;
    logic [NW-1:0] child_node_reg;
    logic [NW-1:0] child_low_reg;
    logic [NW-1:0] b_hold_reg;
    logic [NW-1:0] cidx_reg;
    logic [tecac_pkg::COUNT_W-1:0] res_edges_reg;
    logic [tecac_pkg::COUNT_W-1:0] res_comps_reg;
    logic [tecac_pkg::COUNT_W-1:0] res_leaves_reg;
    logic          res_ovf_reg;

    // memories
    logic [EW-1:0] head_mem [MAX_NODES];
    logic [NW-1:0] tgt_mem  [MAX_HALF_EDGES];
    logic [EW-1:0] nxt_mem  [MAX_HALF_EDGES];
    logic [NW-1:0] disc_mem [MAX_NODES];
    logic [NW-1:0] cs_mem   [MAX_NODES];
    logic [NW-1:0] cn_mem   [MAX_NODES];
    frame_t        ws_mem   [MAX_NODES];
    bridge_t       bl_mem   [MAX_NODES];
    logic [NW-1:0] deg_mem  [MAX_NODES];

    logic [NW-1:0] head_addr, disc_addr, cs_addr, cn_addr, ws_addr, bl_addr, deg_addr;
    logic [HW-1:0] he_addr;
    logic          head_we, he_we, disc_we, cs_we, cn_we, ws_we, bl_we, deg_we;
    logic [EW-1:0] head_wd, nxt_wd, head_rd, nxt_rd;
    logic [NW-1:0] tgt_wd, disc_wd, cs_wd, cn_wd, deg_wd;
    logic [NW-1:0] tgt_rd, disc_rd, cs_rd, cn_rd, deg_rd;
    frame_t        ws_rd;
    bridge_t       bl_wd, bl_rd;

    logic [NW-1:0] na, nb;
    logic [EW-1:0] he_p1;
    logic [CW-1:0] cp_m1, sp_m1, sp_m2;
    logic          visit_new, bridge_found, back_edge;
    logic [NW:0]   edges_sum;

    assign na           = NW'(a_reg);
    assign nb           = NW'(b_reg);
    assign he_p1        = he_cnt_reg + EW'(1);
    assign cp_m1        = cp_reg - CW'(1);
    assign sp_m1        = sp_reg - CW'(1);
    assign sp_m2        = sp_reg - CW'(2);
    assign visit_new    = (disc_rd == '0);
    assign bridge_found = (ws_rd.disc < child_low_reg);
    assign back_edge    = (f_reg.entry == EMPTY) || (pend_entry_reg != (f_reg.entry ^ EW'(1)));
    assign edges_sum    = {1'b0, leaves_reg} + (NW+1)'(1);

    // status to the controller
    always_comb
    begin
        status.edge_ok      = (a_reg != '0) && (b_reg != '0)
                            && (a_reg <= node_count_reg) && (b_reg <= node_count_reg)
                            && (32'(a_reg) < MAX_NODES) && (32'(b_reg) < MAX_NODES);
        status.fits         = (32'(he_cnt_reg) + 2) <= MAX_HALF_EDGES;
        status.last         = last_reg;
        status.cursor_valid = (f_reg.cursor != EMPTY);
        status.visit_new    = visit_new;
        status.comp_root    = (f_reg.disc == f_reg.low);
        status.comp_more    = (cs_rd != f_reg.node) && (cp_reg != '0);
        status.stack_last   = (sp_reg == CW'(1));
        status.count_done   = (idx_reg == bc_reg);
        status.leaf_done    = (idx_reg > CW'(comps_reg));
        status.clear_done   = (idx_reg == CW'(MAX_NODES - 1));
        status.out_busy     = out_valid_reg;
    end

    // memory address and write selection
    always_comb
    begin
        head_addr = '0; head_we = 1'b0; head_wd = EMPTY;
        he_addr   = '0; he_we   = 1'b0; tgt_wd  = '0; nxt_wd = '0;
        disc_addr = '0; disc_we = 1'b0; disc_wd = '0;
        cs_addr   = '0; cs_we   = 1'b0; cs_wd   = '0;
        cn_addr   = '0; cn_we   = 1'b0; cn_wd   = '0;
        ws_addr   = '0; ws_we   = 1'b0;
        bl_addr   = '0; bl_we   = 1'b0; bl_wd   = '0;
        deg_addr  = '0; deg_we  = 1'b0; deg_wd  = '0;
        case (cmd)
            tecac_pkg::CMD_CLEAR_STEP:
            begin
                head_addr = idx_reg[NW-1:0]; head_we = 1'b1; head_wd = EMPTY;
                disc_addr = idx_reg[NW-1:0]; disc_we = 1'b1;
                deg_addr  = idx_reg[NW-1:0]; deg_we  = 1'b1;
            end
            tecac_pkg::CMD_LA_RD:
            begin
                head_addr = na;
            end
            tecac_pkg::CMD_LA_WR:
            begin
                head_addr = na; head_we = 1'b1; head_wd = he_cnt_reg;
                he_addr   = he_cnt_reg[HW-1:0]; he_we = 1'b1;
                tgt_wd    = nb; nxt_wd = head_rd;
            end
            tecac_pkg::CMD_LB_RD:
            begin
                head_addr = nb;
            end
            tecac_pkg::CMD_LB_WR:
            begin
                head_addr = nb; head_we = 1'b1; head_wd = he_p1;
                he_addr   = he_p1[HW-1:0]; he_we = 1'b1;
                tgt_wd    = na; nxt_wd = head_rd;
            end
            tecac_pkg::CMD_W_INIT:
            begin
                head_addr = NW'(1);
                disc_addr = NW'(1); disc_we = 1'b1; disc_wd = NW'(1);
                cs_addr   = '0;     cs_we   = 1'b1; cs_wd   = NW'(1);
            end
            tecac_pkg::CMD_W_EDGE:
            begin
                he_addr = f_reg.cursor[HW-1:0];
            end
            tecac_pkg::CMD_W_DISC:
            begin
                disc_addr = tgt_rd;
            end
            tecac_pkg::CMD_W_DECIDE:
            begin
                head_addr = pend_node_reg;
                disc_addr = pend_node_reg; disc_we = visit_new;
                disc_wd   = vclk_reg + NW'(1);
                cs_addr   = cp_reg[NW-1:0]; cs_we = visit_new; cs_wd = pend_node_reg;
                ws_addr   = sp_m1[NW-1:0];  ws_we = visit_new;
            end
            tecac_pkg::CMD_P_CRD:
            begin
                cs_addr = cp_m1[NW-1:0];
            end
            tecac_pkg::CMD_P_CWR:
            begin
                cn_addr = cs_rd; cn_we = 1'b1; cn_wd = comps_reg;
            end
            tecac_pkg::CMD_P_POP:
            begin
                ws_addr = sp_m2[NW-1:0];
            end
            tecac_pkg::CMD_P_LOAD:
            begin
                bl_addr = bc_reg[NW-1:0]; bl_we = bridge_found;
                bl_wd   = '{parent: ws_rd.node, child: child_node_reg};
            end
            tecac_pkg::CMD_C_LIST:
            begin
                bl_addr = idx_reg[NW-1:0];
            end
            tecac_pkg::CMD_C_CA:
            begin
                cn_addr = bl_rd.parent;
            end
            tecac_pkg::CMD_C_DA, tecac_pkg::CMD_C_DB:
            begin
                deg_addr = cn_rd;
            end
            tecac_pkg::CMD_C_WA:
            begin
                deg_addr = cidx_reg; deg_we = 1'b1; deg_wd = deg_rd + NW'(1);
                cn_addr  = b_hold_reg;
            end
            tecac_pkg::CMD_C_WB:
            begin
                deg_addr = cidx_reg; deg_we = 1'b1; deg_wd = deg_rd + NW'(1);
            end
            tecac_pkg::CMD_L_RD:
            begin
                deg_addr = idx_reg[NW-1:0];
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    // single-port memories with registered read
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_addr] <= head_wd;
        head_rd <= head_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (he_we)
        begin
            tgt_mem[he_addr] <= tgt_wd;
            nxt_mem[he_addr] <= nxt_wd;
        end
        tgt_rd <= tgt_mem[he_addr];
        nxt_rd <= nxt_mem[he_addr];
    end

    always_ff @(posedge clk)
    begin
        if (disc_we)
            disc_mem[disc_addr] <= disc_wd;
        disc_rd <= disc_mem[disc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
            cs_mem[cs_addr] <= cs_wd;
        cs_rd <= cs_mem[cs_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cn_we)
            cn_mem[cn_addr] <= cn_wd;
        cn_rd <= cn_mem[cn_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ws_we)
            ws_mem[ws_addr] <= f_reg;
        ws_rd <= ws_mem[ws_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bl_we)
            bl_mem[bl_addr] <= bl_wd;
        bl_rd <= bl_mem[bl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_addr] <= deg_wd;
        deg_rd <= deg_mem[deg_addr];
    end

    // counters, flags and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= tecac_pkg::NODE_W'(1);
            he_cnt_reg     <= '0;
            vclk_reg       <= '0;
            comps_reg      <= '0;
            leaves_reg     <= '0;
            bc_reg         <= '0;
            idx_reg        <= '0;
            sp_reg         <= '0;
            cp_reg         <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                node_count_reg <= cfg_wr_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd)
                tecac_pkg::CMD_CLEAR_INIT:
                begin
                    he_cnt_reg <= '0;
                    vclk_reg   <= '0;
                    comps_reg  <= '0;
                    leaves_reg <= '0;
                    bc_reg     <= '0;
                    idx_reg    <= '0;
                    sp_reg     <= '0;
                    cp_reg     <= '0;
                    ovf_reg    <= 1'b0;
                end
                tecac_pkg::CMD_CLEAR_STEP, tecac_pkg::CMD_C_WB, tecac_pkg::CMD_L_CHK:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (cmd == tecac_pkg::CMD_L_CHK && deg_rd == NW'(1))
                        leaves_reg <= leaves_reg + NW'(1);
                end
                tecac_pkg::CMD_CHECK:
                begin
                    if (status.edge_ok && !status.fits)
                        ovf_reg <= 1'b1;
                end
                tecac_pkg::CMD_LB_WR:
                begin
                    he_cnt_reg <= he_cnt_reg + EW'(2);
                end
                tecac_pkg::CMD_W_INIT:
                begin
                    vclk_reg <= NW'(1);
                    cp_reg   <= CW'(1);
                end
                tecac_pkg::CMD_W_ROOT, tecac_pkg::CMD_W_PUSH:
                begin
                    sp_reg <= sp_reg + CW'(1);
                end
                tecac_pkg::CMD_W_DECIDE:
                begin
                    if (visit_new)
                    begin
                        vclk_reg <= vclk_reg + NW'(1);
                        cp_reg   <= cp_reg + CW'(1);
                    end
                end
                tecac_pkg::CMD_P_ROOT:
                begin
                    comps_reg <= comps_reg + NW'(1);
                end
                tecac_pkg::CMD_P_CRD:
                begin
                    cp_reg <= cp_m1;
                end
                tecac_pkg::CMD_P_POP:
                begin
                    sp_reg <= sp_m1;
                end
                tecac_pkg::CMD_P_LOAD:
                begin
                    if (bridge_found)
                        bc_reg <= bc_reg + CW'(1);
                end
                tecac_pkg::CMD_C_INIT:
                begin
                    idx_reg <= '0;
                end
                tecac_pkg::CMD_L_INIT:
                begin
                    idx_reg <= CW'(1);
                end
                tecac_pkg::CMD_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // walk frame, held edge and result registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            tecac_pkg::CMD_TAKE:
            begin
                a_reg    <= in_node_a;
                b_reg    <= in_node_b;
                last_reg <= in_last;
            end
            tecac_pkg::CMD_W_ROOT:
            begin
                f_reg <= '{node: NW'(1), entry: EMPTY, cursor: head_rd,
                           disc: NW'(1), low: NW'(1)};
            end
            tecac_pkg::CMD_W_EDGE:
            begin
                pend_entry_reg <= f_reg.cursor;
            end
            tecac_pkg::CMD_W_DISC:
            begin
                pend_node_reg <= tgt_rd;
                f_reg.cursor  <= nxt_rd;
            end
            tecac_pkg::CMD_W_DECIDE:
            begin
                // back edge other than the reverse of the entry lowers low
                if (!visit_new && back_edge && (disc_rd < f_reg.low))
                    f_reg.low <= disc_rd;
            end
            tecac_pkg::CMD_W_PUSH:
            begin
                f_reg <= '{node: pend_node_reg, entry: pend_entry_reg, cursor: head_rd,
                           disc: vclk_reg, low: vclk_reg};
            end
            tecac_pkg::CMD_P_POP:
            begin
                child_low_reg  <= f_reg.low;
                child_node_reg <= f_reg.node;
            end
            tecac_pkg::CMD_P_LOAD:
            begin
                // parent resumes with the lower of its own and the child's low
                f_reg <= '{node: ws_rd.node, entry: ws_rd.entry, cursor: ws_rd.cursor,
                           disc: ws_rd.disc,
                           low: (child_low_reg < ws_rd.low) ? child_low_reg : ws_rd.low};
            end
            tecac_pkg::CMD_C_CA:
            begin
                b_hold_reg <= bl_rd.child;
            end
            tecac_pkg::CMD_C_DA, tecac_pkg::CMD_C_DB:
            begin
                cidx_reg <= cn_rd;
            end
            tecac_pkg::CMD_RESULT:
            begin
                res_edges_reg  <= tecac_pkg::COUNT_W'(edges_sum >> 1);
                res_comps_reg  <= tecac_pkg::COUNT_W'(comps_reg);
                res_leaves_reg <= tecac_pkg::COUNT_W'(leaves_reg);
                res_ovf_reg    <= ovf_reg;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign out_valid           = out_valid_reg;
    assign out_edges_to_add    = res_edges_reg;
    assign out_component_count = res_comps_reg;
    assign out_leaf_components = res_leaves_reg;
    assign out_edge_overflow   = res_ovf_reg;

endmodule
